### rtl/wpm_pkg.sv
// Shared types and byte constants for the wildcard path matcher.
// No dependencies; every other file in rtl/ imports this package.
package wpm_pkg;

   // Special bytes after case folding
   localparam logic [7:0] CH_QUESTION  = 8'h3F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CASE_OFFSET  = 8'h20;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TEXT   = 2'd2,
      CMD_END    = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] byte_value;
   } req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } rsp_type;

   // Classified word handed from the front end to the matcher core
   typedef struct packed {
      cmd_type    op;
      logic [7:0] byte_value;
      logic       is_star;
      logic       is_question;
   } entry_type;

endpackage

### rtl/wpm_front.sv
// Front end: takes request words, folds case and slashes, tags wildcards.
// Depends on wpm_pkg.
module wpm_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  wpm_pkg::req_type    req_data,
   output logic                push_valid,
   input  logic                push_ready,
   output wpm_pkg::entry_type  push_data
);
   import wpm_pkg::*;

   logic [7:0] folded;
   logic       busy_ff;
   logic       busy_in;

   // Fold A-Z to lower case and backslash to slash
   always_comb begin
      folded = req_data.byte_value;
      if (req_data.byte_value == CH_BACKSLASH) begin
         folded = CH_SLASH;
      end else if (req_data.byte_value >= CH_UPPER_A && req_data.byte_value <= CH_UPPER_Z) begin
         folded = req_data.byte_value + CASE_OFFSET;
      end
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid;

   always_comb begin
      push_data.op          = cmd_type'(req_data.command);
      push_data.byte_value  = folded;
      push_data.is_star     = (folded == CH_STAR);
      push_data.is_question = (folded == CH_QUESTION);
   end

   // Track whether a word is waiting on a full queue
   assign busy_in = req_valid && !push_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   // A stalled word must hold until the queue frees a slot
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && $past(req_valid) |-> req_valid)
      else $error("front: request dropped while stalled");

endmodule

### rtl/wpm_queue.sv
// Two-slot queue between the front end and the matcher core.
// Depends on wpm_pkg.
module wpm_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  wpm_pkg::entry_type  in_data,
   output logic                out_valid,
   input  logic                out_pop,
   output wpm_pkg::entry_type  out_data
);
   import wpm_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   entry_type  slot0_ff;
   entry_type  slot0_in;
   entry_type  slot1_ff;
   entry_type  slot1_in;
   logic       push;
   logic       pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot0_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      count_in = count_ff;
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      case ({push, pop})
         2'b10: begin
            count_in = count_ff + 2'd1;
            if (count_ff == 2'd0) begin
               slot0_in = in_data;
            end else begin
               slot1_in = in_data;
            end
         end
         2'b01: begin
            count_in = count_ff - 2'd1;
            slot0_in = slot1_ff;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               slot0_in = in_data;
            end else begin
               slot0_in = slot1_ff;
               slot1_in = in_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

### rtl/wpm_back.sv
// Matcher core: pattern store, active-position vector and result register.
// Depends on wpm_pkg.
module wpm_back #(
   parameter int PATTERN_MAX = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  wpm_pkg::entry_type  head_data,
   output logic                head_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output wpm_pkg::rsp_type    rsp_data
);
   import wpm_pkg::*;

   localparam int LW     = $clog2(PATTERN_MAX + 1);
   localparam int IW     = $clog2(PATTERN_MAX);
   localparam int LEVELS = $clog2(PATTERN_MAX + 1);

   logic [LW-1:0]          len_ff;
   logic [LW-1:0]          len_in;
   logic [PATTERN_MAX-1:0] pos_mask_ff;
   logic [PATTERN_MAX-1:0] pos_mask_in;
   logic                   wild_ff;
   logic                   wild_in;
   logic                   ovf_ff;
   logic                   ovf_in;
   logic [PATTERN_MAX:0]   raw_ff;
   logic [PATTERN_MAX:0]   raw_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_data_ff;
   rsp_type                rsp_data_in;

   logic [7:0]             lit_ff [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] star_ff;
   logic [PATTERN_MAX-1:0] quest_ff;

   logic                   full;
   logic                   wr_en;
   logic [IW-1:0]          wr_idx;
   logic [PATTERN_MAX-1:0] star_eff;
   logic [PATTERN_MAX:0]   act;
   logic [PATTERN_MAX:0]   next_raw;
   logic [PATTERN_MAX:0]   len_hot;
   logic [PATTERN_MAX:0]   start_vec;
   logic                   matched_now;

   assign full      = (len_ff == LW'(PATTERN_MAX));
   assign wr_idx    = len_ff[IW-1:0];
   assign star_eff  = star_ff & pos_mask_ff;
   assign len_hot   = (PATTERN_MAX + 1)'(1) << len_ff;
   assign start_vec = (PATTERN_MAX + 1)'(1);

   // Star closure as a prefix network: a position lights up when any earlier
   // active position reaches it through an unbroken run of stars.
   always_comb begin
      logic [PATTERN_MAX:0] g;
      logic [PATTERN_MAX:0] p;
      g = raw_ff;
      p = {star_eff, 1'b0};
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         for (int j = PATTERN_MAX; j >= (1 << lvl); j--) begin
            g[j] = g[j] | (p[j] & g[j - (1 << lvl)]);
            p[j] = p[j] & p[j - (1 << lvl)];
         end
      end
      act = g;
   end

   // One text byte advances every active position in parallel
   always_comb begin
      next_raw = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (act[i] && pos_mask_ff[i]) begin
            if (star_ff[i]) begin
               next_raw[i] = 1'b1;
            end else if (quest_ff[i] || lit_ff[i] == head_data.byte_value) begin
               next_raw[i+1] = 1'b1;
            end
         end
      end
      // Plain pattern: a new start at every byte, and a hit stays
      if (!wild_ff) begin
         next_raw = next_raw | start_vec | (act & len_hot);
      end
   end

   assign matched_now = (len_ff != '0) && act[len_ff];

   assign head_pop = head_valid &&
                     (head_data.op != CMD_END || !rsp_valid_ff || rsp_ready);

   always_comb begin
      len_in       = len_ff;
      pos_mask_in  = pos_mask_ff;
      wild_in      = wild_ff;
      ovf_in       = ovf_ff;
      raw_in       = raw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      if (head_pop) begin
         case (head_data.op)
            CMD_CLEAR: begin
               len_in      = '0;
               pos_mask_in = '0;
               wild_in     = 1'b0;
               ovf_in      = 1'b0;
               raw_in      = start_vec;
            end
            CMD_APPEND: begin
               if (!full) begin
                  wr_en       = 1'b1;
                  len_in      = len_ff + LW'(1);
                  pos_mask_in = pos_mask_ff | (PATTERN_MAX'(1) << len_ff);
                  wild_in     = wild_ff | head_data.is_star | head_data.is_question;
               end else begin
                  ovf_in = 1'b1;
               end
               raw_in = start_vec;
            end
            CMD_TEXT: begin
               raw_in = next_raw;
            end
            CMD_END: begin
               rsp_valid_in                 = 1'b1;
               rsp_data_in.matched          = matched_now;
               rsp_data_in.pattern_overflow = ovf_ff;
               raw_in                       = start_vec;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         pos_mask_ff  <= '0;
         wild_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         raw_ff       <= start_vec;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         pos_mask_ff  <= pos_mask_in;
         wild_ff      <= wild_in;
         ovf_ff       <= ovf_in;
         raw_ff       <= raw_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (wr_en) begin
         lit_ff[wr_idx]   <= head_data.byte_value;
         star_ff[wr_idx]  <= head_data.is_star;
         quest_ff[wr_idx] <= head_data.is_question;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      len_ff <= LW'(PATTERN_MAX))
      else $error("back: pattern length beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      $countones(pos_mask_ff) == int'(len_ff))
      else $error("back: position mask out of step with length");

   assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> full)
      else $error("back: overflow flagged with room left");

   assert property (@(posedge clock) disable iff (reset)
      wild_ff |-> len_ff != '0)
      else $error("back: wildcard flag on empty pattern");

   assert property (@(posedge clock) disable iff (reset)
      head_pop && head_data.op == CMD_END |=> rsp_valid_ff)
      else $error("back: end of text produced no result");

endmodule

### rtl/wildcard_path_matcher_unit.sv
// Top level of the wildcard path matcher: front end, queue, matcher core.
// Depends on wpm_pkg, wpm_front, wpm_queue and wpm_back.
//
//   channel | direction | payload type      | word
//   req_    | in        | wpm_pkg::req_type | command + byte_value
//   rsp_    | out       | wpm_pkg::rsp_type | matched + pattern_overflow
//
// Cycles: one word per clock sustained, for every command, while rsp_ready
// takes each result; an end-of-text word waits while a result is held on rsp_.
// A result reaches rsp_ via a queue slot and the core's result register. The
// cycle time is set by the active-position update in the core: star closure
// prefix network (log2 of PATTERN_MAX+1 levels) followed by the per-position
// byte compare.
// Reset: synchronous, clears pattern length, flags and the active vector; the
// pattern store needs no clearing pass, only positions below the length count.
// Stalls: the two-slot queue absorbs a stalled rsp_ side; req_ready drops only
// while both slots hold words, which happens only after the core has held an
// end-of-text word waiting on rsp_ready.
module wildcard_path_matcher_unit #(
   parameter int PATTERN_MAX = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wpm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wpm_pkg::rsp_type rsp_data
);
   import wpm_pkg::*;

   // Front end to queue
   logic      push_valid;
   logic      push_ready;
   entry_type push_data;

   // Queue to core
   logic      head_valid;
   logic      head_pop;
   entry_type head_data;

   // Classify and fold each request word
   wpm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // Hold classified words while the core waits on the result side
   wpm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (head_valid),
      .out_pop   (head_pop),
      .out_data  (head_data)
   );

   // Advance the pattern and active positions, register the result
   wpm_back #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

### sim/wpm_checker.sv
// Checker for the wildcard path matcher: watches req_ and rsp_, predicts results, compares.
// Depends on wpm_pkg for the word types, command codes and byte constants.
`timescale 1ns / 100ps

module wpm_checker #(
   parameter int PATTERN_MAX = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  wpm_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  wpm_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               open_results
);
   import wpm_pkg::*;

   logic [7:0]       pat_mem [PATTERN_MAX];
   int unsigned      pat_len;
   logic             wild_seen;
   logic             ovf_seen;
   logic [PATTERN_MAX:0] live;
   rsp_type          verdict_q [$];

   function automatic logic [7:0] fold_path_byte(logic [7:0] b);
      if (b == CH_BACKSLASH) return CH_SLASH;
      if (b >= CH_UPPER_A && b <= CH_UPPER_Z) return b + CASE_OFFSET;
      return b;
   endfunction

   // a live '*' also opens the position after it
   function automatic logic [PATTERN_MAX:0] close_stars(logic [PATTERN_MAX:0] v);
      for (int i = 0; i < pat_len; i++)
         if (v[i] && pat_mem[i] == CH_STAR) v[i+1] = 1'b1;
      return v;
   endfunction

   function automatic logic [PATTERN_MAX:0] fresh_positions();
      logic [PATTERN_MAX:0] v;
      v    = '0;
      v[0] = 1'b1;
      return close_stars(v);
   endfunction

   function automatic logic [PATTERN_MAX:0] advance_text(logic [7:0] c);
      logic [PATTERN_MAX:0] nxt;
      nxt = '0;
      for (int i = 0; i < pat_len; i++) begin
         if (live[i]) begin
            if (pat_mem[i] == CH_STAR) nxt[i] = 1'b1;
            else if (pat_mem[i] == CH_QUESTION || pat_mem[i] == c) nxt[i+1] = 1'b1;
         end
      end
      // plain pattern: substring search, a hit stays
      if (!wild_seen) begin
         nxt[0] = 1'b1;
         if (live[pat_len]) nxt[pat_len] = 1'b1;
      end
      return close_stars(nxt);
   endfunction

   task automatic apply_word(input req_type w);
      logic [7:0] c;
      rsp_type    r;
      c = fold_path_byte(w.byte_value);
      case (cmd_type'(w.command))
         CMD_CLEAR: begin
            pat_len   = 0;
            wild_seen = 1'b0;
            ovf_seen  = 1'b0;
            live      = fresh_positions();
         end
         CMD_APPEND: begin
            if (pat_len < PATTERN_MAX) begin
               pat_mem[pat_len] = c;
               pat_len++;
               if (c == CH_STAR || c == CH_QUESTION) wild_seen = 1'b1;
            end else begin
               ovf_seen = 1'b1;
            end
            live = fresh_positions();
         end
         CMD_TEXT: live = advance_text(c);
         default: begin
            r.matched          = (pat_len != 0) && live[pat_len];
            r.pattern_overflow = ovf_seen;
            verdict_q = {verdict_q, r};
            live = fresh_positions();
         end
      endcase
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         apply_word('{command: CMD_CLEAR, byte_value: 8'h00});
         verdict_q.delete();
      end else begin
         // check results first; an end word taken now cannot answer this edge
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               report_mismatch("result word with no end-of-text pending");
            end else begin
               want = verdict_q.pop_front();
               if (rsp_data.matched !== want.matched)
                  report_mismatch($sformatf("matched %b, expected %b",
                                            rsp_data.matched, want.matched));
               if (rsp_data.pattern_overflow !== want.pattern_overflow)
                  report_mismatch($sformatf("pattern_overflow %b, expected %b",
                                            rsp_data.pattern_overflow,
                                            want.pattern_overflow));
            end
         end
         if (req_valid && req_ready) apply_word(req_data);
      end
      open_results = verdict_q.size();
   end

endmodule

### sim/tb_wildcard_path_matcher_unit.sv
// Top of the wildcard path matcher testbench: clock, reset, stimulus and verdict.
// Depends on wpm_pkg, wpm_checker and the wildcard_path_matcher_unit RTL.
`timescale 1ns / 100ps

module tb_wildcard_path_matcher_unit;
   import wpm_pkg::*;

   localparam int PATTERN_MAX  = 64;
   localparam int RANDOM_WORDS = 1150;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int open_results;

   // Idle plan per phase, in percent of cycles: free running, sender idle,
   // receiver stalling, then both.
   int send_plan  [4] = '{0, 83, 0, 33};
   int stall_plan [4] = '{0, 0, 83, 33};
   int send_idle_pct  = 0;
   int stall_pct      = 0;
   int words_sent     = 0;
   int directed_words;

   wildcard_path_matcher_unit #(
      .PATTERN_MAX(PATTERN_MAX)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   wpm_checker #(
      .PATTERN_MAX(PATTERN_MAX)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .open_results   (open_results)
   );

   always #5 clock = ~clock;

   // Drive the result side's ready at the falling edge from the current stall rate.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Hard stop: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("wildcard_path_matcher_unit test failed");
      $finish;
   end

   // Offer one word; call at a falling edge, return at the falling edge
   // after it is taken. Valid is only lowered when an idle cycle is drawn.
   task automatic send_word(input cmd_type cmd, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{command: cmd, byte_value: b};
      // sample ready at the edge itself, before the block updates
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   // Small path-like alphabet, both letter cases, both slashes, glob bytes
   // (ordinary bytes inside text) and now and then any byte at all.
   function automatic logic [7:0] pick_text_byte();
      case ($urandom_range(11))
         0:       return CH_STAR;
         1:       return CH_QUESTION;
         2:       return CH_SLASH;
         3:       return CH_BACKSLASH;
         4, 5:    return 8'($urandom);
         default: return CH_UPPER_A + 8'($urandom_range(3))
                         + ($urandom_range(1) ? CASE_OFFSET : 8'h00);
      endcase
   endfunction

   function automatic logic [7:0] pick_pattern_byte();
      case ($urandom_range(9))
         0, 1:    return CH_STAR;
         2:       return CH_QUESTION;
         default: return pick_text_byte();
      endcase
   endfunction

   // One session: clear, load a pattern, then run a few texts against it.
   // Most texts are built from the pattern so they match; some get broken.
   task automatic run_pattern_session();
      logic [7:0] pat_q [$];
      logic [7:0] txt_q [$];
      logic [7:0] b;
      int         n_pat;
      bit         wild;
      // mostly short patterns, sometimes past the store's end
      n_pat = ($urandom_range(19) == 0) ? $urandom_range(PATTERN_MAX + 6, PATTERN_MAX - 4)
                                        : $urandom_range(8);
      send_word(CMD_CLEAR, 8'($urandom));
      repeat (n_pat) begin
         b = pick_pattern_byte();
         send_word(CMD_APPEND, b);
         if (pat_q.size() < PATTERN_MAX) pat_q = {pat_q, b};
      end
      repeat ($urandom_range(4, 1)) begin
         wild = 1'b0;
         foreach (pat_q[i]) if (pat_q[i] == CH_STAR || pat_q[i] == CH_QUESTION) wild = 1'b1;
         txt_q.delete();
         // plain pattern: bury it inside some surrounding bytes
         if (!wild) repeat ($urandom_range(3)) txt_q = {txt_q, pick_text_byte()};
         foreach (pat_q[i]) begin
            b = pat_q[i];
            if (b == CH_STAR) begin
               repeat ($urandom_range(3)) txt_q = {txt_q, pick_text_byte()};
            end else if (b == CH_QUESTION) begin
               txt_q = {txt_q, pick_text_byte()};
            end else begin
               // flip letter case and swap slash kinds; both fold the same
               if ((b | CASE_OFFSET) >= (CH_UPPER_A | CASE_OFFSET) &&
                   (b | CASE_OFFSET) <= (CH_UPPER_Z | CASE_OFFSET) && $urandom_range(1))
                  b = b ^ CASE_OFFSET;
               else if (b == CH_SLASH || b == CH_BACKSLASH)
                  b = $urandom_range(1) ? CH_SLASH : CH_BACKSLASH;
               txt_q = {txt_q, b};
            end
         end
         if (!wild) repeat ($urandom_range(3)) txt_q = {txt_q, pick_text_byte()};
         // break some texts: one byte off, or throw it away for noise
         if ($urandom_range(4) == 0) begin
            if (txt_q.size() != 0 && $urandom_range(1)) begin
               txt_q[$urandom_range(txt_q.size() - 1)] = pick_text_byte();
            end else begin
               txt_q.delete();
               repeat ($urandom_range(12)) txt_q = {txt_q, pick_text_byte()};
            end
         end
         foreach (txt_q[i]) begin
            // now and then grow the pattern in mid-text; matching restarts
            if ($urandom_range(49) == 0) begin
               b = pick_pattern_byte();
               send_word(CMD_APPEND, b);
               if (pat_q.size() < PATTERN_MAX) pat_q = {pat_q, b};
            end
            send_word(CMD_TEXT, txt_q[i]);
         end
         send_word(CMD_END, 8'($urandom));
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed words, no idling.
      // empty pattern, empty text: no match
      send_word(CMD_END, 8'h00);
      // upper-case literal folds to lower, found inside the text
      send_word(CMD_APPEND, "A");
      send_word(CMD_TEXT, "x");
      send_word(CMD_TEXT, "a");
      send_word(CMD_END, 8'h00);
      // same pattern, empty text
      send_word(CMD_END, 8'hFF);
      // star alone matches empty text
      send_word(CMD_CLEAR, 8'h00);
      send_word(CMD_APPEND, CH_STAR);
      send_word(CMD_END, 8'h00);
      // backslash in pattern folds to slash; star in text meets star in pattern
      send_word(CMD_APPEND, CH_BACKSLASH);
      send_word(CMD_TEXT, CH_STAR);
      send_word(CMD_TEXT, CH_SLASH);
      send_word(CMD_END, 8'h00);
      // question mark takes a star from the text; top byte value as literal
      send_word(CMD_CLEAR, 8'hFF);
      send_word(CMD_APPEND, CH_QUESTION);
      send_word(CMD_APPEND, 8'hFF);
      send_word(CMD_TEXT, CH_STAR);
      send_word(CMD_TEXT, 8'hFF);
      send_word(CMD_END, 8'h00);
      // too short a text
      send_word(CMD_TEXT, 8'h00);
      send_word(CMD_END, 8'h00);
      // clear ignores its byte; empty pattern never matches
      send_word(CMD_CLEAR, 8'hA5);
      send_word(CMD_TEXT, "z");
      send_word(CMD_END, 8'h5A);
      directed_words = words_sent;

      // Random sessions, one idle plan per phase, with stray words between.
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = send_plan[p];
         stall_pct     = stall_plan[p];
         while (words_sent < directed_words + (p + 1) * RANDOM_WORDS / 4) begin
            if ($urandom_range(9) == 0)
               repeat ($urandom_range(4, 1))
                  send_word(cmd_type'(2'($urandom_range(3))), 8'($urandom));
            else
               run_pattern_session();
         end
      end
      req_valid <= 1'b0;

      // Drain: every end word answered, then wait out any strays.
      wait (open_results == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("wildcard_path_matcher_unit test passed");
      else
         $display("wildcard_path_matcher_unit test failed");
      $finish;
   end

endmodule

### sim.f
rtl/wpm_pkg.sv
rtl/wpm_front.sv
rtl/wpm_queue.sv
rtl/wpm_back.sv
rtl/wildcard_path_matcher_unit.sv
sim/wpm_checker.sv
sim/tb_wildcard_path_matcher_unit.sv
